[rtl/core/cia_pkg.sv]
// Shared types and constants for the checked integer ALU.
// Holds the operation and status codes and the control record passed between stages.
// No dependencies.
`default_nettype none
package cia_pkg;

  localparam int MAX_WIDTH_DEF = 64;
  localparam int FIELD_W       = 64;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  typedef struct packed {
    kind_t   kind;
    logic    sgn;
    logic    neg;
    status_t st;
  } ctrl_t;

endpackage
`default_nettype wire

[rtl/core/cia_front.sv]
// Decode stage: width mask, operand magnitudes, add/subtract results and divide checks.
// Depends on cia_pkg.
`default_nettype none
module cia_front #(
  parameter int W = cia_pkg::MAX_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             vld_i,
  input  wire logic [1:0]       kind_i,
  input  wire logic [W-1:0]     a_i,
  input  wire logic [W-1:0]     b_i,
  input  wire logic [1:0]       code_i,
  input  wire logic             sgn_i,
  output logic                  vld_o,
  output cia_pkg::ctrl_t        ctrl_o,
  output logic [W-1:0]          mask_o,
  output logic [W-1:0]          sign_o,
  output logic [W-1:0]          res_o,
  output logic [W-1:0]          ma_o,
  output logic [W-1:0]          mb_o
);

  logic           vld_r;
  cia_pkg::ctrl_t ctrl_r, ctrl_nxt;
  logic [W-1:0]   mask_r, mask_nxt;
  logic [W-1:0]   sign_r, sign_nxt;
  logic [W-1:0]   res_r, res_nxt;
  logic [W-1:0]   ma_r, ma_nxt;
  logic [W-1:0]   mb_r, mb_nxt;
  logic [W-1:0]   a, b;
  logic [W:0]     sum;
  logic           sa, sb, rs;

  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask_nxt[i] = (i < (8 << code_i));
    end
    sign_nxt = mask_nxt ^ (mask_nxt >> 1);
    a  = a_i & mask_nxt;
    b  = b_i & mask_nxt;
    sa = |(a & sign_nxt);
    sb = |(b & sign_nxt);
    ma_nxt = (sgn_i && sa) ? ((~a + 1'b1) & mask_nxt) : a;
    mb_nxt = (sgn_i && sb) ? ((~b + 1'b1) & mask_nxt) : b;
    sum = {1'b0, a} + {1'b0, b};
    ctrl_nxt.kind = cia_pkg::kind_t'(kind_i);
    ctrl_nxt.sgn  = sgn_i;
    ctrl_nxt.neg  = sgn_i && (sa != sb);
    ctrl_nxt.st   = cia_pkg::ST_OK;
    res_nxt = '0;
    rs = 1'b0;
    case (ctrl_nxt.kind)
      cia_pkg::KIND_ADD: begin
        res_nxt = sum[W-1:0] & mask_nxt;
        rs = |(res_nxt & sign_nxt);
        if (sgn_i ? (sa == sb && rs != sa) : (sum > {1'b0, mask_nxt})) begin
          ctrl_nxt.st = cia_pkg::ST_OVF;
        end
      end
      cia_pkg::KIND_SUB: begin
        res_nxt = (a - b) & mask_nxt;
        rs = |(res_nxt & sign_nxt);
        if (sgn_i ? (sa != sb && rs != sa) : (b > a)) begin
          ctrl_nxt.st = cia_pkg::ST_OVF;
        end
      end
      cia_pkg::KIND_DIV: begin
        if (b == '0) begin
          ctrl_nxt.st = cia_pkg::ST_DIVZ;
        end else if (sgn_i && a == sign_nxt && b == mask_nxt) begin
          ctrl_nxt.st = cia_pkg::ST_OVF;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
    if (adv) begin
      ctrl_r <= ctrl_nxt;
      mask_r <= mask_nxt;
      sign_r <= sign_nxt;
      res_r  <= res_nxt;
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign ctrl_o = ctrl_r;
  assign mask_o = mask_r;
  assign sign_o = sign_r;
  assign res_o  = res_r;
  assign ma_o   = ma_r;
  assign mb_o   = mb_r;

endmodule
`default_nettype wire

[rtl/core/cia_mul.sv]
// Two-stage multiplier of operand magnitudes with an exact range check.
// Partial products in the first stage, their sum and the check in the second. Uses cia_pkg.
`default_nettype none
module cia_mul #(
  parameter int W = cia_pkg::MAX_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             vld_i,
  input  wire cia_pkg::ctrl_t   ctrl_i,
  input  wire logic [W-1:0]     mask_i,
  input  wire logic [W-1:0]     sign_i,
  input  wire logic [W-1:0]     res_i,
  input  wire logic [W-1:0]     ma_i,
  input  wire logic [W-1:0]     mb_i,
  output logic                  vld_o,
  output cia_pkg::ctrl_t        ctrl_o,
  output logic [W-1:0]          mask_o,
  output logic [W-1:0]          res_o,
  output logic [W-1:0]          ma_o,
  output logic [W-1:0]          mb_o
);

  localparam int H  = (W + 1) / 2;
  localparam int PW = 2 * H;
  localparam int FW = 2 * PW;

  // First stage: four half-width partial products.
  logic [H-1:0]   al, ah, bl, bh;
  logic [PW-1:0]  ll_r, hh_r;
  logic [PW:0]    mid_r;
  logic [W-1:0]   lim_r, lim_nxt;
  logic           v1_r;
  cia_pkg::ctrl_t c1_r;
  logic [W-1:0]   mask1_r, res1_r, ma1_r, mb1_r;

  always_comb begin
    al = ma_i[H-1:0];
    bl = mb_i[H-1:0];
    ah = H'(ma_i >> H);
    bh = H'(mb_i >> H);
    if (!ctrl_i.sgn) begin
      lim_nxt = mask_i;
    end else if (ctrl_i.neg) begin
      lim_nxt = sign_i;
    end else begin
      lim_nxt = sign_i - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= vld_i;
    end
    if (adv) begin
      ll_r    <= PW'(al) * PW'(bl);
      hh_r    <= PW'(ah) * PW'(bh);
      mid_r   <= (PW+1)'(PW'(al) * PW'(bh)) + (PW+1)'(PW'(ah) * PW'(bl));
      lim_r   <= lim_nxt;
      c1_r    <= ctrl_i;
      mask1_r <= mask_i;
      res1_r  <= res_i;
      ma1_r   <= ma_i;
      mb1_r   <= mb_i;
    end
  end

  // Second stage: full product, range check and signed result bits.
  logic [FW-1:0]  prod;
  logic [W-1:0]   plow;
  cia_pkg::ctrl_t c2_nxt;
  logic [W-1:0]   res2_nxt;
  logic           v2_r;
  cia_pkg::ctrl_t c2_r;
  logic [W-1:0]   mask2_r, res2_r, ma2_r, mb2_r;

  always_comb begin
    prod = FW'(ll_r) + (FW'(mid_r) << H) + (FW'(hh_r) << PW);
    plow = prod[W-1:0];
    c2_nxt   = c1_r;
    res2_nxt = res1_r;
    if (c1_r.kind == cia_pkg::KIND_MUL) begin
      res2_nxt = (c1_r.neg ? (~plow + 1'b1) : plow) & mask1_r;
      if (prod > FW'(lim_r)) begin
        c2_nxt.st = cia_pkg::ST_OVF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      c2_r    <= c2_nxt;
      mask2_r <= mask1_r;
      res2_r  <= res2_nxt;
      ma2_r   <= ma1_r;
      mb2_r   <= mb1_r;
    end
  end

  assign vld_o  = v2_r;
  assign ctrl_o = c2_r;
  assign mask_o = mask2_r;
  assign res_o  = res2_r;
  assign ma_o   = ma2_r;
  assign mb_o   = mb2_r;

endmodule
`default_nettype wire

[rtl/core/cia_div.sv]
// Pipelined restoring divider of magnitudes, one quotient bit per register stage.
// Carries the control record and earlier results alongside. Uses cia_pkg.
`default_nettype none
module cia_div #(
  parameter int W = cia_pkg::MAX_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             vld_i,
  input  wire cia_pkg::ctrl_t   ctrl_i,
  input  wire logic [W-1:0]     mask_i,
  input  wire logic [W-1:0]     res_i,
  input  wire logic [W-1:0]     ma_i,
  input  wire logic [W-1:0]     mb_i,
  output logic                  vld_o,
  output cia_pkg::ctrl_t        ctrl_o,
  output logic [W-1:0]          mask_o,
  output logic [W-1:0]          res_o,
  output logic [W-1:0]          quo_o
);

  logic           vld_r  [W];
  cia_pkg::ctrl_t ctrl_r [W];
  logic [W-1:0]   mask_r [W];
  logic [W-1:0]   res_r  [W];
  logic [W-1:0]   rem_r  [W];
  logic [W-1:0]   quo_r  [W];
  logic [W-1:0]   mb_r   [W];

  for (genvar k = 0; k < W; k++) begin : g_step
    logic           v_in;
    cia_pkg::ctrl_t c_in;
    logic [W-1:0]   mask_in, res_in, rem_in, quo_in, mb_in;
    logic [W:0]     trial, diff;
    logic           ge;
    logic [W-1:0]   rem_nxt, quo_nxt;

    if (k == 0) begin : g_first
      assign v_in    = vld_i;
      assign c_in    = ctrl_i;
      assign mask_in = mask_i;
      assign res_in  = res_i;
      assign rem_in  = '0;
      assign quo_in  = ma_i;
      assign mb_in   = mb_i;
    end else begin : g_next
      assign v_in    = vld_r[k-1];
      assign c_in    = ctrl_r[k-1];
      assign mask_in = mask_r[k-1];
      assign res_in  = res_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign mb_in   = mb_r[k-1];
    end

    // Shift the next dividend bit into the partial remainder and try the divisor.
    always_comb begin
      trial   = {rem_in, quo_in[W-1]};
      diff    = trial - {1'b0, mb_in};
      ge      = (trial >= {1'b0, mb_in});
      rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
      quo_nxt = {quo_in[W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= v_in;
      end
      if (adv) begin
        ctrl_r[k] <= c_in;
        mask_r[k] <= mask_in;
        res_r[k]  <= res_in;
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        mb_r[k]   <= mb_in;
      end
    end
  end

  assign vld_o  = vld_r[W-1];
  assign ctrl_o = ctrl_r[W-1];
  assign mask_o = mask_r[W-1];
  assign res_o  = res_r[W-1];
  assign quo_o  = quo_r[W-1];

endmodule
`default_nettype wire

[rtl/core/checked_integer_alu.sv]
// Top level of the checked integer ALU: stream ports, stage chain and output register.
// Depends on cia_pkg, cia_front, cia_mul and cia_div.
//
// Usage: one operation enters per transfer on the in_ channel and one result leaves
// per transfer on the out_ channel, in the same order. Add, subtract, multiply and
// divide are checked exactly at the selected width (8, 16, 32 or 64 bits, clamped to
// MAX_WIDTH); on overflow or division by zero the value is zero and the status says why.
// The path runs through one decode stage, two multiply stages, one divider stage per
// quotient bit and the output register. Every operation takes the same path, so one
// transfer per cycle is sustained while the receiver keeps out_tready high.
// All stages move together; when the receiver holds out_tready low with a result
// waiting, the whole chain holds and in_tready drops, and nothing is lost or repeated.
// Empty stages still advance while the output register is free.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers keep junk.
`default_nettype none
module checked_integer_alu #(
  parameter int MAX_WIDTH = cia_pkg::MAX_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // kind[1:0], operand_a[65:2], operand_b[129:66], width_code[131:130],
  // is_signed[132], zero fill [135:133]
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // value[63:0], status[65:64], zero fill [71:66]
  output logic [71:0]       out_tdata
);

  localparam int W = MAX_WIDTH;

  logic adv;

  logic           f_vld;
  cia_pkg::ctrl_t f_ctrl;
  logic [W-1:0]   f_mask, f_sign, f_res, f_ma, f_mb;

  logic           m_vld;
  cia_pkg::ctrl_t m_ctrl;
  logic [W-1:0]   m_mask, m_res, m_ma, m_mb;

  logic           d_vld;
  cia_pkg::ctrl_t d_ctrl;
  logic [W-1:0]   d_mask, d_res, d_quo;

  logic [W-1:0]   fin_val;
  logic           out_vld_r;
  logic [cia_pkg::FIELD_W-1:0] value_r, value_nxt;
  cia_pkg::status_t            status_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  cia_front #(.W(W)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (in_tvalid),
    .kind_i (in_tdata[1:0]),
    .a_i    (in_tdata[2 +: W]),
    .b_i    (in_tdata[66 +: W]),
    .code_i (in_tdata[131:130]),
    .sgn_i  (in_tdata[132]),
    .vld_o  (f_vld),
    .ctrl_o (f_ctrl),
    .mask_o (f_mask),
    .sign_o (f_sign),
    .res_o  (f_res),
    .ma_o   (f_ma),
    .mb_o   (f_mb)
  );

  cia_mul #(.W(W)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (f_vld),
    .ctrl_i (f_ctrl),
    .mask_i (f_mask),
    .sign_i (f_sign),
    .res_i  (f_res),
    .ma_i   (f_ma),
    .mb_i   (f_mb),
    .vld_o  (m_vld),
    .ctrl_o (m_ctrl),
    .mask_o (m_mask),
    .res_o  (m_res),
    .ma_o   (m_ma),
    .mb_o   (m_mb)
  );

  cia_div #(.W(W)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (m_vld),
    .ctrl_i (m_ctrl),
    .mask_i (m_mask),
    .res_i  (m_res),
    .ma_i   (m_ma),
    .mb_i   (m_mb),
    .vld_o  (d_vld),
    .ctrl_o (d_ctrl),
    .mask_o (d_mask),
    .res_o  (d_res),
    .quo_o  (d_quo)
  );

  // Apply the quotient sign, then force zero on any error.
  always_comb begin
    if (d_ctrl.kind == cia_pkg::KIND_DIV) begin
      fin_val = (d_ctrl.neg ? (~d_quo + 1'b1) : d_quo) & d_mask;
    end else begin
      fin_val = d_res & d_mask;
    end
    if (d_ctrl.st != cia_pkg::ST_OK) begin
      fin_val = '0;
    end
    value_nxt = cia_pkg::FIELD_W'(fin_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_vld;
    end
    if (adv) begin
      value_r  <= value_nxt;
      status_r <= d_ctrl.st;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, status_r, value_r};

endmodule
`default_nettype wire

[rtl/core/cia_checker.sv]
// Port-level checker for the checked integer ALU, bound to the top level.
// Sees only the top level's ports; no package dependency.
`default_nettype none
module cia_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:64] != 2'd3)
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] != 2'd0 |-> out_tdata[63:0] == 64'd0)
    else $error("nonzero value with error status");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind checked_integer_alu cia_props u_cia_props (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

[dv/cia_checker.sv]
`timescale 1ns / 1ps
// Checker for the checked integer ALU: watches both stream channels, predicts each result
// and compares it in order with what leaves the block. Depends on cia_pkg.
module cia_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [135:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [71:0]  out_tdata,
  output int                fail_count,
  output int                pending
);
  import cia_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } alu_result_t;

  alu_result_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [63:0] abs_at(logic [63:0] x, logic [63:0] sbit, logic [63:0] m);
    return ((x & sbit) != 0) ? ((~x + 64'd1) & m) : x;
  endfunction

  function automatic alu_result_t compute_result(logic [135:0] d);
    kind_t       op;
    logic [1:0]  wc;
    logic        sgn, sa, sb;
    int          w;
    logic [63:0] m, sbit, a, b, r, ma, mb, lim;
    logic [64:0] sum;
    status_t     st;
    alu_result_t res;
    op   = kind_t'(d[1:0]);
    wc   = d[131:130];
    sgn  = d[132];
    w    = 8 << wc;
    m    = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    sbit = 64'd1 << (w - 1);
    a    = d[65:2] & m;
    b    = d[129:66] & m;
    sa   = (a & sbit) != 0;
    sb   = (b & sbit) != 0;
    r    = '0;
    st   = ST_OK;
    case (op)
      KIND_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r = sum[63:0] & m;
        if (sgn) begin
          if (sa == sb && (((r & sbit) != 0) != sa)) st = ST_OVF;
        end else if (sum > {1'b0, m}) st = ST_OVF;
      end
      KIND_SUB: begin
        r = (a - b) & m;
        if (sgn) begin
          if (sa != sb && (((r & sbit) != 0) != sa)) st = ST_OVF;
        end else if (b > a) st = ST_OVF;
      end
      KIND_MUL: begin
        r = (a * b) & m;
        if (sgn) begin
          ma  = abs_at(a, sbit, m);
          mb  = abs_at(b, sbit, m);
          lim = (sa == sb) ? (sbit - 64'd1) : sbit;
          if (ma != 0 && mb != 0 && mb > lim / ma) st = ST_OVF;
        end else if (a != 0 && b > m / a) st = ST_OVF;
      end
      default: begin
        if (b == 0) st = ST_DIVZ;
        else if (sgn) begin
          if (a == sbit && b == m) st = ST_OVF;
          else begin
            r = abs_at(a, sbit, m) / abs_at(b, sbit, m);
            if (sa != sb) r = (~r + 64'd1) & m;
          end
        end else r = a / b;
      end
    endcase
    if (st != ST_OK) r = '0;
    res.value  = r & m;
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [65:0] got, logic [65:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[65:0], '0);
        end else begin
          want = result_q.pop_front();
          if (out_tdata[63:0] !== want.value)
            report_mismatch("value", out_tdata[63:0], want.value);
          if (out_tdata[65:64] !== want.status)
            report_mismatch("status", out_tdata[65:64], want.status);
        end
      end
      if (in_tvalid && in_tready) result_q.push_back(compute_result(in_tdata));
    end
  end
endmodule

[dv/tb_checked_integer_alu.sv]
`timescale 1ns / 1ps
// Top of the checked integer ALU testbench: clock, reset, stimulus and verdict.
// Depends on cia_pkg, checked_integer_alu and cia_checker.
module tb_checked_integer_alu;
  import cia_pkg::*;

  localparam int LATENCY   = 68;
  localparam int MAX_CYCLE = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  int           fail_count;
  int           pending;
  int           cycle = 0;

  always #6 clk = ~clk;

  checked_integer_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  cia_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLE) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiver stalls a random number of cycles before each result.
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8);
      repeat (gap) @(posedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      out_tready <= 1'b0;
    end
  end

  function automatic logic [63:0] rand_operand(logic [1:0] wc);
    logic [63:0] v;
    logic [63:0] m;
    m = (wc == 2'd3) ? '1 : ((64'd1 << (8 << wc)) - 64'd1);
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = 64'd0;
      1: v = 64'd1;
      2: v = '1;
      3: v = (64'd1 << ((8 << wc) - 1)) | (v & ~m);
      4: v = (v & ~m) | (m >> 1);
      5: v = {$urandom, $urandom} & (m >> ((8 << wc) / 2));
      default: ;
    endcase
    return v;
  endfunction

  // Transfers one operation, after an optional random gap.
  task automatic send_op(kind_t op, logic [63:0] a, logic [63:0] b, logic [1:0] wc,
                         logic sgn, bit random_gap);
    int gap;
    gap = random_gap ? (($urandom_range(3) == 0) ? 0 : $urandom_range(8)) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {3'b000, sgn, wc, b, a, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    kind_t op;
    logic [1:0] wc;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, division by zero, most negative over minus one, borrow from zero.
    for (int k = 0; k < 4; k++) begin
      op = kind_t'(k);
      send_op(op, '1, '1, 2'd3, 1'b0, 1'b0);
      send_op(op, 64'h8000_0000_0000_0000, '1, 2'd3, 1'b1, 1'b0);
      send_op(op, 64'h80, 64'hFF, 2'd0, 1'b1, 1'b0);
      send_op(op, 64'h0, 64'h1, 2'd1, 1'b0, 1'b1);
      send_op(op, 64'h7FFF_FFFF, 64'h0, 2'd2, 1'b1, 1'b0);
    end
    send_op(KIND_MUL, 64'hF0, 64'h08, 2'd0, 1'b1, 1'b0);
    send_op(KIND_MUL, 64'hFFFF_FFFF_FFFF_FF80, 64'h1, 2'd0, 1'b1, 1'b0);
    send_op(KIND_DIV, 64'hF9, 64'h02, 2'd0, 1'b1, 1'b0);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    @(posedge clk);
    for (int i = 0; i < 950; i++) begin
      wc = 2'($urandom_range(3));
      send_op(kind_t'($urandom_range(3)), rand_operand(wc), rand_operand(wc), wc,
              1'($urandom_range(1)), (i / 100) % 2 == 0);
      if (i == 475) begin
        in_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
